// ----- sv/lfu_cache_with_lru_tiebreak_defines.svh -----
// Assertion macros shared by the checker of the LFU cache.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef LFU_CACHE_WITH_LRU_TIEBREAK_DEFINES_SVH
`define LFU_CACHE_WITH_LRU_TIEBREAK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfu cache check failed");

// The consequent must hold in the cycle after the antecedent.
`define LFU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfu cache check failed");

`endif

// ----- sv/lfu_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types of the LFU cache with recency tie-break.
// Used by the channel interfaces, the top level and its checker; depends on nothing.
package lfu_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int KEY_W           = 32;
    localparam int VALUE_W         = 32;
    localparam int CAPACITY_W      = 5;

    localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = 5'd16;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } op_t;

endpackage

// ----- sv/lfu_req_if.sv -----
`timescale 1ns / 1ps
// Request channel of the LFU cache: one word is a get or put with key and value.
// Depends on lfu_pkg for the field widths.
interface lfu_req_if;

    logic                                valid;
    logic                                ready;
    logic                                operation;
    logic signed [lfu_pkg::KEY_W-1:0]    key;
    logic signed [lfu_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output operation, output key, output value, input ready);
    modport sink (input valid, input operation, input key, input value, output ready);

endinterface

// ----- sv/lfu_rsp_if.sv -----
`timescale 1ns / 1ps
// Response channel of the LFU cache: one word carries the hit flag and the read value.
// Depends on lfu_pkg for the field widths.
interface lfu_rsp_if;

    logic                                valid;
    logic                                ready;
    logic                                found;
    logic signed [lfu_pkg::VALUE_W-1:0]  read_value;

    modport source (output valid, output found, output read_value, input ready);
    modport sink (input valid, input found, input read_value, output ready);

endinterface

// ----- sv/lfu_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
// Stands alone; used by the LFU cache for its entry store.
module lfu_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                    clk,
    input  logic                    we,
    input  logic [ADDR_W-1:0]       waddr,
    input  logic [WIDTH-1:0]        wdata,
    input  logic [ADDR_W-1:0]       raddr,
    output logic [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/lfu_cache_with_lru_tiebreak.sv -----
`timescale 1ns / 1ps
// Top level of the LFU key/value cache with least-recently-used tie-break.
// Depends on lfu_pkg, lfu_req_if, lfu_rsp_if and lfu_ram.
//
// Usage: a get or put word enters on req; exactly one word leaves on rsp with
// found (key was present before the operation) and read_value (stored value on
// a get hit, zero otherwise). The capacity register is written through cfg_we
// and cfg_wdata; the user must write it only while the cache is idle, and the
// block itself does not enforce this. It resets to 16. All entries live in one
// RAM of MAX_ENTRIES words with a registered read port. Every operation makes
// one sweep over all entries to find a key match, the eviction victim and a
// free slot, one entry per cycle. A hit (except a put at zero capacity) or an
// insert then makes a second read-modify-write sweep that updates recency
// ranks and counts. The cache takes one operation at a time; req.ready is
// high only while no operation is in progress.
// The response waits in an output register, so the next request is accepted
// while the receiver stalls; that request finishes its sweeps and then waits
// until the register frees. Reset clears all valid bits and the occupancy.
module lfu_cache_with_lru_tiebreak #(
    parameter int MAX_ENTRIES = lfu_pkg::MAX_ENTRIES_DEF,
    parameter int COUNT_BITS  = lfu_pkg::COUNT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    lfu_req_if.sink                           req,
    lfu_rsp_if.source                         rsp,
    input  logic                              cfg_we,
    input  logic [lfu_pkg::CAPACITY_W-1:0]    cfg_wdata
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

    typedef struct packed {
        logic [lfu_pkg::KEY_W-1:0]   key;
        logic [lfu_pkg::VALUE_W-1:0] value;
        logic [COUNT_BITS-1:0]       count;
        logic [IDX_W-1:0]            rank;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_UPDATE,
        S_RESP
    } state_t;

    typedef enum logic {
        M_TOUCH,
        M_INSERT
    } mode_t;

    state_t                            state_reg;
    mode_t                             mode_reg;
    logic [lfu_pkg::CAPACITY_W-1:0]    capacity_reg;
    logic [MAX_ENTRIES-1:0]            valid_reg;
    logic [OCC_W-1:0]                  occ_reg;
    lfu_pkg::op_t                      op_reg;
    logic [lfu_pkg::KEY_W-1:0]         key_reg;
    logic [lfu_pkg::VALUE_W-1:0]       value_reg;
    logic [IDX_W-1:0]                  idx_reg;
    logic                              issue_reg;
    logic                              pipe_vld_reg;
    logic [IDX_W-1:0]                  pipe_idx_reg;
    logic                              hit_reg;
    logic [IDX_W-1:0]                  hit_idx_reg;
    logic [IDX_W-1:0]                  hit_rank_reg;
    logic [lfu_pkg::VALUE_W-1:0]       hit_value_reg;
    logic                              vic_found_reg;
    logic [IDX_W-1:0]                  vic_idx_reg;
    logic [COUNT_BITS-1:0]             vic_count_reg;
    logic [IDX_W-1:0]                  vic_rank_reg;
    logic                              free_found_reg;
    logic [IDX_W-1:0]                  free_idx_reg;
    logic                              evict_reg;
    logic [IDX_W-1:0]                  slot_idx_reg;
    logic                              found_reg;
    logic [lfu_pkg::VALUE_W-1:0]       rdval_reg;
    logic                              rsp_valid_reg;

    entry_t                            rd_entry;
    entry_t                            wr_entry;
    logic [ENTRY_W-1:0]                rd_word;
    logic                              wr_en;
    logic                              rd_live;
    logic                              key_match;
    logic                              better;
    logic                              pass_done;
    logic                              occ_full;
    logic                              do_evict;
    logic                              slot_ok;
    logic [IDX_W-1:0]                  slot_sel;

    lfu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (pipe_idx_reg),
        .wdata (wr_entry),
        .raddr (idx_reg),
        .rdata (rd_word)
    );

    assign rd_entry  = entry_t'(rd_word);
    assign rd_live   = valid_reg[pipe_idx_reg];
    assign key_match = rd_live && (rd_entry.key == key_reg);
    assign better    = rd_live && (!vic_found_reg || (rd_entry.count < vic_count_reg) ||
                       ((rd_entry.count == vic_count_reg) && (rd_entry.rank > vic_rank_reg)));
    assign pass_done = !issue_reg && pipe_vld_reg;

    assign occ_full = (32'(occ_reg) >= 32'(capacity_reg)) ||
                      (32'(occ_reg) >= 32'(MAX_ENTRIES));
    assign do_evict = occ_full && vic_found_reg;
    assign slot_ok  = free_found_reg || do_evict;

    always_comb
    begin
        if (free_found_reg && !(do_evict && (vic_idx_reg < free_idx_reg)))
        begin
            slot_sel = free_idx_reg;
        end
        else
        begin
            slot_sel = vic_idx_reg;
        end
    end

    always_comb
    begin
        wr_en    = 1'b0;
        wr_entry = rd_entry;
        if ((state_reg == S_UPDATE) && pipe_vld_reg)
        begin
            if (mode_reg == M_TOUCH)
            begin
                if (pipe_idx_reg == hit_idx_reg)
                begin
                    wr_en         = 1'b1;
                    wr_entry.rank = '0;
                    if (rd_entry.count != '1)
                    begin
                        wr_entry.count = rd_entry.count + COUNT_BITS'(1);
                    end
                    if (op_reg == lfu_pkg::OP_PUT)
                    begin
                        wr_entry.value = value_reg;
                    end
                end
                else if (rd_live && (rd_entry.rank < hit_rank_reg))
                begin
                    wr_en         = 1'b1;
                    wr_entry.rank = rd_entry.rank + IDX_W'(1);
                end
            end
            else
            begin
                if (pipe_idx_reg == slot_idx_reg)
                begin
                    wr_en          = 1'b1;
                    wr_entry.key   = key_reg;
                    wr_entry.value = value_reg;
                    wr_entry.count = COUNT_BITS'(1);
                    wr_entry.rank  = '0;
                end
                else if (rd_live && !(evict_reg && (pipe_idx_reg == vic_idx_reg)))
                begin
                    // Closing the victim's gap and making room at the front cancel out.
                    wr_en = 1'b1;
                    if (!(evict_reg && (rd_entry.rank > vic_rank_reg)))
                    begin
                        wr_entry.rank = rd_entry.rank + IDX_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= M_TOUCH;
            capacity_reg   <= lfu_pkg::CAPACITY_RESET;
            valid_reg      <= '0;
            occ_reg        <= '0;
            op_reg         <= lfu_pkg::OP_GET;
            key_reg        <= '0;
            value_reg      <= '0;
            idx_reg        <= '0;
            issue_reg      <= 1'b0;
            pipe_vld_reg   <= 1'b0;
            pipe_idx_reg   <= '0;
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
            hit_rank_reg   <= '0;
            hit_value_reg  <= '0;
            vic_found_reg  <= 1'b0;
            vic_idx_reg    <= '0;
            vic_count_reg  <= '0;
            vic_rank_reg   <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            evict_reg      <= 1'b0;
            slot_idx_reg   <= '0;
            found_reg      <= 1'b0;
            rdval_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end

            if (rsp_valid_reg && rsp.ready && (state_reg != S_RESP))
            begin
                rsp_valid_reg <= 1'b0;
            end

            if ((state_reg == S_SCAN) || (state_reg == S_UPDATE))
            begin
                if (issue_reg)
                begin
                    pipe_vld_reg <= 1'b1;
                    pipe_idx_reg <= idx_reg;
                    if (idx_reg == LAST_IDX)
                    begin
                        issue_reg <= 1'b0;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    pipe_vld_reg <= 1'b0;
                end
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg         <= lfu_pkg::op_t'(req.operation);
                        key_reg        <= req.key;
                        value_reg      <= req.value;
                        hit_reg        <= 1'b0;
                        vic_found_reg  <= 1'b0;
                        free_found_reg <= 1'b0;
                        idx_reg        <= '0;
                        issue_reg      <= 1'b1;
                        pipe_vld_reg   <= 1'b0;
                        state_reg      <= S_SCAN;
                    end
                end

                S_SCAN:
                begin
                    if (pipe_vld_reg)
                    begin
                        if (key_match && !hit_reg)
                        begin
                            hit_reg       <= 1'b1;
                            hit_idx_reg   <= pipe_idx_reg;
                            hit_rank_reg  <= rd_entry.rank;
                            hit_value_reg <= rd_entry.value;
                        end
                        if (better)
                        begin
                            vic_found_reg <= 1'b1;
                            vic_idx_reg   <= pipe_idx_reg;
                            vic_count_reg <= rd_entry.count;
                            vic_rank_reg  <= rd_entry.rank;
                        end
                        if (!rd_live && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= pipe_idx_reg;
                        end
                    end
                    if (pass_done)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end

                S_DECIDE:
                begin
                    idx_reg   <= '0;
                    issue_reg <= 1'b1;
                    evict_reg <= do_evict;
                    slot_idx_reg <= slot_sel;
                    if (op_reg == lfu_pkg::OP_GET)
                    begin
                        mode_reg  <= M_TOUCH;
                        state_reg <= hit_reg ? S_UPDATE : S_RESP;
                    end
                    else if (capacity_reg == '0)
                    begin
                        state_reg <= S_RESP;
                    end
                    else if (hit_reg)
                    begin
                        mode_reg  <= M_TOUCH;
                        state_reg <= S_UPDATE;
                    end
                    else if (slot_ok)
                    begin
                        mode_reg  <= M_INSERT;
                        state_reg <= S_UPDATE;
                    end
                    else
                    begin
                        state_reg <= S_RESP;
                    end
                end

                S_UPDATE:
                begin
                    if (pass_done)
                    begin
                        if (mode_reg == M_INSERT)
                        begin
                            if (evict_reg)
                            begin
                                valid_reg[vic_idx_reg] <= 1'b0;
                            end
                            valid_reg[slot_idx_reg] <= 1'b1;
                            occ_reg <= occ_reg + OCC_W'(1) - OCC_W'(evict_reg);
                        end
                        state_reg <= S_RESP;
                    end
                end

                S_RESP:
                begin
                    issue_reg <= 1'b0;
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        found_reg <= hit_reg;
                        if ((op_reg == lfu_pkg::OP_GET) && hit_reg)
                        begin
                            rdval_reg <= hit_value_reg;
                        end
                        else
                        begin
                            rdval_reg <= '0;
                        end
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.found      = found_reg;
    assign rsp.read_value = rdval_reg;

endmodule

// ----- sv/lfu_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker of the LFU cache, bound to the top level below.
// Depends on lfu_pkg and the assertion macros in the defines header.
`include "lfu_cache_with_lru_tiebreak_defines.svh"

module lfu_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 req_valid,
    input logic                                 req_ready,
    input logic                                 rsp_valid,
    input logic                                 rsp_ready,
    input logic                                 rsp_found,
    input logic signed [lfu_pkg::VALUE_W-1:0]   rsp_read_value
);

    // An accepted word keeps the cache busy for at least the next cycle.
    `LFU_ASSERT_NEXT(busy_after_accept, clk, rst_n, req_valid && req_ready, !req_ready)

    // No response word can appear in the cycle after a request is taken.
    `LFU_ASSERT_NEXT(no_instant_rsp, clk, rst_n, req_valid && req_ready, !$rose(rsp_valid))

    // A miss never reports a value.
    `LFU_ASSERT_NOW(miss_reads_zero, clk, rst_n, rsp_valid && !rsp_found, rsp_read_value == '0)

    // A stalled response word holds.
    `LFU_ASSERT_NEXT(rsp_holds, clk, rst_n, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_found) && $stable(rsp_read_value))

endmodule

bind lfu_cache_with_lru_tiebreak lfu_checker u_lfu_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_found      (rsp.found),
    .rsp_read_value (rsp.read_value)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the LFU cache with least-recently-used tie-break.
// Depends on lfu_pkg, lfu_req_if, lfu_rsp_if and lfu_cache_with_lru_tiebreak.
module testbench;

    localparam int MAX_E       = lfu_pkg::MAX_ENTRIES_DEF;
    localparam int COUNT_W     = lfu_pkg::COUNT_BITS_DEF;
    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 193;
    localparam int POOL_N      = 20;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 40;
    localparam int REPORT_MAX  = 200;

    typedef struct packed {
        lfu_pkg::op_t                op;
        logic [lfu_pkg::KEY_W-1:0]   key;
        logic [lfu_pkg::VALUE_W-1:0] value;
    } req_word_t;

    typedef struct packed {
        logic                        found;
        logic [lfu_pkg::VALUE_W-1:0] read_value;
    } rsp_word_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [lfu_pkg::CAPACITY_W-1:0] cfg_wdata;

    lfu_req_if req_ch ();
    lfu_rsp_if rsp_ch ();

    lfu_cache_with_lru_tiebreak #(
        .MAX_ENTRIES (MAX_E),
        .COUNT_BITS  (COUNT_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow copy of the cache contents.
    logic                        ent_valid [MAX_E];
    logic [lfu_pkg::KEY_W-1:0]   ent_key   [MAX_E];
    logic [lfu_pkg::VALUE_W-1:0] ent_val   [MAX_E];
    logic [COUNT_W-1:0]          ent_cnt   [MAX_E];
    int                          ent_rank  [MAX_E];
    int                          fill;
    int                          cap_model;

    req_word_t   pending_words [$];
    rsp_word_t   lookup_results [$];
    logic [lfu_pkg::KEY_W-1:0] key_pool [POOL_N];
    int          error_count = 0;
    int          replies_seen;
    int          idle_cycles;

    function automatic void cache_access(input req_word_t w, output rsp_word_t r);
        int hit_idx;
        int victim;
        int slot;
        int vr;
        int eff_cap;
        int j;
        hit_idx = -1;
        for (j = 0; j < MAX_E; j++)
            if (hit_idx < 0 && ent_valid[j] && ent_key[j] == w.key)
                hit_idx = j;
        r.found = (hit_idx >= 0);
        r.read_value = '0;
        eff_cap = (cap_model > MAX_E) ? MAX_E : cap_model;
        if (hit_idx >= 0 && (w.op == lfu_pkg::OP_GET || eff_cap != 0))
        begin
            if (w.op == lfu_pkg::OP_GET)
                r.read_value = ent_val[hit_idx];
            else
                ent_val[hit_idx] = w.value;
            if (ent_cnt[hit_idx] != '1)
                ent_cnt[hit_idx] = ent_cnt[hit_idx] + COUNT_W'(1);
            vr = ent_rank[hit_idx];
            for (j = 0; j < MAX_E; j++)
                if (ent_valid[j] && ent_rank[j] < vr)
                    ent_rank[j]++;
            ent_rank[hit_idx] = 0;
        end
        else if (hit_idx < 0 && w.op == lfu_pkg::OP_PUT && eff_cap != 0)
        begin
            if (fill >= eff_cap)
            begin
                victim = -1;
                for (j = 0; j < MAX_E; j++)
                    if (ent_valid[j] && (victim < 0 || ent_cnt[j] < ent_cnt[victim] ||
                        (ent_cnt[j] == ent_cnt[victim] && ent_rank[j] > ent_rank[victim])))
                        victim = j;
                if (victim >= 0)
                begin
                    vr = ent_rank[victim];
                    for (j = 0; j < MAX_E; j++)
                        if (ent_valid[j] && ent_rank[j] > vr)
                            ent_rank[j]--;
                    ent_valid[victim] = 1'b0;
                    fill--;
                end
            end
            slot = -1;
            for (j = 0; j < MAX_E; j++)
                if (slot < 0 && !ent_valid[j])
                    slot = j;
            if (slot >= 0)
            begin
                for (j = 0; j < MAX_E; j++)
                    if (ent_valid[j])
                        ent_rank[j]++;
                ent_valid[slot] = 1'b1;
                ent_key[slot]   = w.key;
                ent_val[slot]   = w.value;
                ent_cnt[slot]   = COUNT_W'(1);
                ent_rank[slot]  = 0;
                fill++;
            end
        end
    endfunction

    function automatic void add_word(input lfu_pkg::op_t op,
                                     input logic [lfu_pkg::KEY_W-1:0] k,
                                     input logic [lfu_pkg::VALUE_W-1:0] v);
        req_word_t w;
        w.op    = op;
        w.key   = k;
        w.value = v;
        pending_words.push_back(w);
    endfunction

    // Most keys come from a small skewed pool so that hits, evictions and
    // count ties are common; the rest are fully random.
    function automatic req_word_t random_word();
        req_word_t w;
        w.op    = lfu_pkg::op_t'($urandom_range(0, 1));
        w.value = $urandom;
        if ($urandom_range(0, 99) < 85)
            w.key = key_pool[$urandom_range(0, $urandom_range(0, POOL_N - 1))];
        else
            w.key = $urandom;
        return w;
    endfunction

    task automatic wait_drained();
        while (pending_words.size() != 0 || req_ch.valid || lookup_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_capacity(input logic [lfu_pkg::CAPACITY_W-1:0] c);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        cap_model = c;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Request driver: bursts of random length separated by random gaps.
    req_word_t next_word;
    int        burst_left;
    int        gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.operation <= lfu_pkg::OP_GET;
            req_ch.key       <= '0;
            req_ch.value     <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                req_ch.valid <= 1'b0;
            end
            else if (pending_words.size() != 0)
            begin
                next_word = pending_words.pop_front();
                req_ch.valid     <= 1'b1;
                req_ch.operation <= next_word.op;
                req_ch.key       <= next_word.key;
                req_ch.value     <= next_word.value;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 60);
                    gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 40);
                end
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Response receiver: its own random stall pattern plus one long hold-off.
    int   rx_mode;
    int   rx_timer;
    int   long_hold;
    logic long_done;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rx_mode   <= 0;
            rx_timer  <= 0;
            long_hold <= 0;
            long_done <= 1'b0;
        end
        else if (long_hold > 0)
        begin
            long_hold    <= long_hold - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (!long_done && replies_seen >= 400)
        begin
            long_hold    <= 300;
            long_done    <= 1'b1;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rx_timer == 0)
            begin
                rx_mode  <= $urandom_range(0, 3);
                rx_timer <= $urandom_range(20, 120);
            end
            else
                rx_timer <= rx_timer - 1;
            case (rx_mode)
                0: rsp_ch.ready <= 1'b1;
                1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                default: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // Monitor: predicts on each accepted request and checks each accepted reply.
    rsp_word_t got_word;
    rsp_word_t want_word;
    req_word_t seen_req;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            replies_seen <= 0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got_word.found      = rsp_ch.found;
                got_word.read_value = rsp_ch.read_value;
                replies_seen <= replies_seen + 1;
                if (lookup_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("%0t: unexpected word, expected none, actual found=%0b value=%h",
                                 $time, got_word.found, got_word.read_value);
                end
                else
                begin
                    want_word = lookup_results.pop_front();
                    if (got_word.found !== want_word.found)
                    begin
                        error_count++;
                        if (error_count <= REPORT_MAX)
                            $display("%0t: found expected %0b actual %0b",
                                     $time, want_word.found, got_word.found);
                    end
                    if (got_word.read_value !== want_word.read_value)
                    begin
                        error_count++;
                        if (error_count <= REPORT_MAX)
                            $display("%0t: read_value expected %h actual %h",
                                     $time, want_word.read_value, got_word.read_value);
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                seen_req.op    = lfu_pkg::op_t'(req_ch.operation);
                seen_req.key   = req_ch.key;
                seen_req.value = req_ch.value;
                cache_access(seen_req, want_word);
                lookup_results.push_back(want_word);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    int phase_caps [PHASES];

    initial
    begin
        int p;
        int n;
        int j;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        req_ch.valid     = 1'b0;
        req_ch.operation = lfu_pkg::OP_GET;
        req_ch.key       = '0;
        req_ch.value     = '0;
        rsp_ch.ready     = 1'b0;
        idle_cycles      = 0;
        for (j = 0; j < MAX_E; j++)
        begin
            ent_valid[j] = 1'b0;
            ent_key[j]   = '0;
            ent_val[j]   = '0;
            ent_cnt[j]   = '0;
            ent_rank[j]  = 0;
        end
        fill      = 0;
        cap_model = lfu_pkg::CAPACITY_RESET;
        phase_caps = '{16, 31, 3, 0, 1, 5, 17, 2, 8, 16};
        for (j = 0; j < POOL_N; j++)
            key_pool[j] = $urandom;
        key_pool[3] = 32'h8000_0000;
        key_pool[7] = 32'h7FFF_FFFF;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening at the reset capacity: empty miss, key and value
        // extremes, overwrite, then repeated hits on one key.
        add_word(lfu_pkg::OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        add_word(lfu_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        add_word(lfu_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        add_word(lfu_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        add_word(lfu_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        add_word(lfu_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
        add_word(lfu_pkg::OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_word(lfu_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        add_word(lfu_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
        add_word(lfu_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        add_word(lfu_pkg::OP_GET, 32'h0000_0001, 32'h0000_0000);
        for (n = 0; n < 14; n++)
            add_word(lfu_pkg::OP_GET, 32'h0000_0000, $urandom);
        wait_drained();

        for (p = 0; p < PHASES; p++)
        begin
            write_capacity(lfu_pkg::CAPACITY_W'(phase_caps[p]));
            for (j = 0; j < POOL_N; j++)
                if ($urandom_range(0, 2) == 0)
                    key_pool[j] = $urandom;
            for (n = 0; n < PHASE_WORDS; n++)
                pending_words.push_back(random_word());
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0 && lookup_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
